// ----- design/lprta_pkg.sv -----
package lprta_pkg;

    // pipeline sizing
    localparam int CORDIC_STEPS_DEFAULT = 16;
    localparam int COORD_W              = 54;
    localparam int ANGLE_W              = 35;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 30;

    localparam logic [CFG_IDX_W-1:0] REG_FOV_MIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOV_MAX       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_PERIOD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RING_SUPPLIED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INT_SUPPLIED  = 3'd5;

    // angles in rad * 2^30
    localparam logic [32:0] PI_Q30     = 33'd3373259426;
    localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;

    // floor(2^64 / two pi), reciprocal for the time offset
    localparam logic [31:0] TWO_PI_RECIP = 32'(64'hFFFF_FFFF_FFFF_FFFF / 64'(TWO_PI_Q30));

    typedef struct packed {
        logic signed [31:0] x_pos;
        logic signed [31:0] y_pos;
        logic signed [31:0] z_pos;
        logic [31:0]        in_intensity;
        logic [15:0]        in_ring;
        logic               last_point;
    } point_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [31:0]        intensity;
        logic [6:0]         ring_index;
        logic [29:0]        time_offset_ns;
        logic               cloud_end;
    } result_t;

    // atan(2^-i) in rad * 2^30, rounded to nearest
    function automatic logic signed [ANGLE_W-1:0] atan_entry(input int i);
        logic [63:0] v;
        case (i)
            0:       v = 64'd843314857;
            1:       v = 64'd497837829;
            2:       v = 64'd263043837;
            3:       v = 64'd133525159;
            4:       v = 64'd67021687;
            5:       v = 64'd33543516;
            6:       v = 64'd16775851;
            7:       v = 64'd8388437;
            8:       v = 64'd4194283;
            9:       v = 64'd2097149;
            10:      v = 64'd1048576;
            default: v = (i > 62) ? 64'd0 : ((64'd1 << 30) >> i);
        endcase
        return v[ANGLE_W-1:0];
    endfunction

endpackage

// ----- design/lprta_cordic.sv -----
module lprta_cordic #(
    parameter int STEPS  = lprta_pkg::CORDIC_STEPS_DEFAULT,
    parameter int SIDE_W = 1
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic signed [lprta_pkg::COORD_W-1:0]  in_x,
    input  logic signed [lprta_pkg::COORD_W-1:0]  in_y,
    input  logic [SIDE_W-1:0]                     in_side,
    output logic                                  out_valid,
    output logic signed [lprta_pkg::COORD_W-1:0]  out_x,
    output logic signed [lprta_pkg::ANGLE_W-1:0]  out_angle,
    output logic [SIDE_W-1:0]                     out_side
);

    localparam int W  = lprta_pkg::COORD_W;
    localparam int AW = lprta_pkg::ANGLE_W;

    logic                 valid_reg [STEPS];
    logic signed [W-1:0]  x_reg     [STEPS];
    logic signed [W-1:0]  y_reg     [STEPS];
    logic signed [AW-1:0] a_reg     [STEPS];
    logic [SIDE_W-1:0]    side_reg  [STEPS];

    for (genvar s = 0; s < STEPS; s++)
    begin : g_stage
        localparam logic signed [AW-1:0] ATAN_S = lprta_pkg::atan_entry(s);

        logic                 valid_in;
        logic signed [W-1:0]  x_in;
        logic signed [W-1:0]  y_in;
        logic signed [AW-1:0] a_in;
        logic [SIDE_W-1:0]    side_in;
        logic signed [W-1:0]  x_next;
        logic signed [W-1:0]  y_next;
        logic signed [AW-1:0] a_next;

        // stage inputs
        if (s == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign x_in     = in_x;
            assign y_in     = in_y;
            assign a_in     = '0;
            assign side_in  = in_side;
        end
        else
        begin : g_rest
            assign valid_in = valid_reg[s-1];
            assign x_in     = x_reg[s-1];
            assign y_in     = y_reg[s-1];
            assign a_in     = a_reg[s-1];
            assign side_in  = side_reg[s-1];
        end

        // one vectoring rotation, driving y towards zero
        always_comb
        begin
            if (!y_in[W-1])
            begin
                x_next = x_in + (y_in >>> s);
                y_next = y_in - (x_in >>> s);
                a_next = a_in + ATAN_S;
            end
            else
            begin
                x_next = x_in - (y_in >>> s);
                y_next = y_in + (x_in >>> s);
                a_next = a_in - ATAN_S;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[s]    <= x_next;
            y_reg[s]    <= y_next;
            a_reg[s]    <= a_next;
            side_reg[s] <= side_in;
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_x     = x_reg[STEPS-1];
    assign out_angle = a_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

// ----- design/lprta_div.sv -----
module lprta_div #(
    parameter int NUM_W  = 42,
    parameter int DEN_W  = 34,
    parameter int QUO_W  = 8,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QUO_W-1:0]  out_quo,
    output logic [SIDE_W-1:0] out_side
);

    localparam int TW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic              valid_reg [QUO_W];
    logic [TW-1:0]     rem_reg   [QUO_W];
    logic [DEN_W-1:0]  den_reg   [QUO_W];
    logic [QUO_W-1:0]  quo_reg   [QUO_W];
    logic [SIDE_W-1:0] side_reg  [QUO_W];

    // restoring division, one quotient bit per stage, msb first
    for (genvar s = 0; s < QUO_W; s++)
    begin : g_stage
        localparam int K = QUO_W - 1 - s;

        logic              valid_in;
        logic [TW-1:0]     rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [QUO_W-1:0]  quo_in;
        logic [SIDE_W-1:0] side_in;
        logic [TW-1:0]     trial;
        logic [TW-1:0]     rem_next;
        logic [QUO_W-1:0]  quo_next;

        if (s == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = TW'(in_num);
            assign den_in   = in_den;
            assign quo_in   = '0;
            assign side_in  = in_side;
        end
        else
        begin : g_rest
            assign valid_in = valid_reg[s-1];
            assign rem_in   = rem_reg[s-1];
            assign den_in   = den_reg[s-1];
            assign quo_in   = quo_reg[s-1];
            assign side_in  = side_reg[s-1];
        end

        // compare and subtract the shifted divisor
        always_comb
        begin
            trial    = TW'(den_in) << K;
            rem_next = rem_in;
            quo_next = quo_in;
            if (rem_in >= trial)
            begin
                rem_next    = rem_in - trial;
                quo_next[K] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s]  <= rem_next;
            den_reg[s]  <= den_in;
            quo_reg[s]  <= quo_next;
            side_reg[s] <= side_in;
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

// ----- design/lidar_point_ring_time_annotator_unit.sv -----
// Annotates one lidar point per clock with a ring index and a time offset within
// the rotation. A point is taken whenever start is high (busy stays low) and its
// result later appears on result with a one-cycle done strobe; the receiver
// cannot hold results off, so it must take every strobe. The pipeline holds
// the input register, two CORDIC vectoring pipelines of CORDIC_STEPS stages in
// series (azimuth and range, then elevation) with one register between them,
// two set-up stages for the divisions, an 8-stage restoring divider for the
// ring, two stages of reciprocal multiplication for the time offset, and the
// output register. Configuration must only be written while no point is in
// flight.
module lidar_point_ring_time_annotator_unit #(
    parameter int CORDIC_STEPS = lprta_pkg::CORDIC_STEPS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cfg_wr_en,
    input  logic [lprta_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lprta_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  lprta_pkg::point_t                   point,
    output logic                                done,
    output lprta_pkg::result_t                  result
);

    localparam int W  = lprta_pkg::COORD_W;
    localparam int AW = lprta_pkg::ANGLE_W;

    typedef struct packed {
        logic              xneg;
        logic              yneg;
        logic              xyzero;
        lprta_pkg::point_t pt;
    } a_side_t;

    typedef struct packed {
        logic              origin;
        logic [32:0]       az;
        lprta_pkg::point_t pt;
    } b_side_t;

    typedef struct packed {
        logic [62:0]       time_num;
        logic              ring_zero;
        logic [7:0]        top;
        lprta_pkg::point_t pt;
    } rd_side_t;

    typedef struct packed {
        logic [7:0]        ring_q;
        logic              ring_zero;
        logic [7:0]        top;
        lprta_pkg::point_t pt;
    } td_side_t;

    // configuration registers
    logic signed [17:0] fov_min_reg;
    logic signed [17:0] fov_max_reg;
    logic [7:0]         lines_reg;
    logic [29:0]        period_reg;
    logic               ring_sup_reg;
    logic               int_sup_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fov_min_reg  <= -18'sd17157;
            fov_max_reg  <= 18'sd17157;
            lines_reg    <= 8'd32;
            period_reg   <= 30'd107526882;
            ring_sup_reg <= 1'b0;
            int_sup_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                lprta_pkg::REG_FOV_MIN:       fov_min_reg  <= cfg_data[17:0];
                lprta_pkg::REG_FOV_MAX:       fov_max_reg  <= cfg_data[17:0];
                lprta_pkg::REG_LINE_COUNT:    lines_reg    <= cfg_data[7:0];
                lprta_pkg::REG_SCAN_PERIOD:   period_reg   <= cfg_data;
                lprta_pkg::REG_RING_SUPPLIED: ring_sup_reg <= cfg_data[0];
                lprta_pkg::REG_INT_SUPPLIED:  int_sup_reg  <= cfg_data[0];
                default:                      ;
            endcase
        end
    end

    // every cycle takes a point
    assign busy = 1'b0;

    // magnitude with 16 guard bits
    function automatic logic signed [W-1:0] abs_guard(input logic signed [31:0] v);
        logic signed [32:0] w;
        logic [32:0]        m;
        w = 33'(v);
        m = w[32] ? 33'(-w) : 33'(w);
        return W'({m, 16'b0});
    endfunction

    // input stage
    logic                s0_valid_reg;
    logic signed [W-1:0] s0_x_reg;
    logic signed [W-1:0] s0_y_reg;
    logic signed [W-1:0] s0_z_reg;
    logic                s0_zneg_reg;
    a_side_t             s0_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_x_reg           <= abs_guard(point.x_pos);
        s0_y_reg           <= abs_guard(point.y_pos);
        s0_z_reg           <= abs_guard(point.z_pos);
        s0_zneg_reg        <= point.z_pos[31];
        s0_side_reg.xneg   <= point.x_pos[31];
        s0_side_reg.yneg   <= point.y_pos[31];
        s0_side_reg.xyzero <= (point.x_pos == '0) && (point.y_pos == '0);
        s0_side_reg.pt     <= point;
    end

    // azimuth and range, and z carried through the same gain
    logic                 a_valid;
    logic signed [W-1:0]  a_x;
    logic signed [AW-1:0] a_angle;
    a_side_t              a_side;
    logic signed [W-1:0]  z_x;
    logic                 z_neg;

    lprta_cordic #(
        .STEPS  (CORDIC_STEPS),
        .SIDE_W ($bits(a_side_t))
    ) u_cordic_az (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .in_x      (s0_x_reg),
        .in_y      (s0_y_reg),
        .in_side   (s0_side_reg),
        .out_valid (a_valid),
        .out_x     (a_x),
        .out_angle (a_angle),
        .out_side  (a_side)
    );

    lprta_cordic #(
        .STEPS  (CORDIC_STEPS),
        .SIDE_W (1)
    ) u_cordic_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .in_x      (s0_z_reg),
        .in_y      ('0),
        .in_side   (s0_zneg_reg),
        .out_valid (),
        .out_x     (z_x),
        .out_angle (),
        .out_side  (z_neg)
    );

    // quadrant unfolding and clamp of the azimuth
    logic signed [36:0] az_w;
    logic [32:0]        az_c;
    logic signed [W-1:0] kz;

    always_comb
    begin
        if (a_side.xyzero)
        begin
            az_w = '0;
        end
        else if (!a_side.xneg && !a_side.yneg)
        begin
            az_w = 37'(a_angle);
        end
        else if (a_side.xneg && !a_side.yneg)
        begin
            az_w = signed'(37'(lprta_pkg::PI_Q30)) - 37'(a_angle);
        end
        else if (a_side.xneg)
        begin
            az_w = signed'(37'(lprta_pkg::PI_Q30)) + 37'(a_angle);
        end
        else
        begin
            az_w = signed'(37'(lprta_pkg::TWO_PI_Q30)) - 37'(a_angle);
        end

        if (az_w < 0)
        begin
            az_c = '0;
        end
        else if (az_w > signed'(37'(lprta_pkg::TWO_PI_Q30 - 33'd1)))
        begin
            az_c = lprta_pkg::TWO_PI_Q30 - 33'd1;
        end
        else
        begin
            az_c = az_w[32:0];
        end

        kz = z_neg ? -z_x : z_x;
    end

    logic                p1_valid_reg;
    logic signed [W-1:0] p1_r_reg;
    logic signed [W-1:0] p1_kz_reg;
    b_side_t             p1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= a_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_r_reg           <= a_x;
        p1_kz_reg          <= kz;
        p1_side_reg.origin <= (a_x == '0) && (kz == '0);
        p1_side_reg.az     <= az_c;
        p1_side_reg.pt     <= a_side.pt;
    end

    // elevation
    logic                 b_valid;
    logic signed [AW-1:0] b_angle;
    b_side_t              b_side;

    lprta_cordic #(
        .STEPS  (CORDIC_STEPS),
        .SIDE_W ($bits(b_side_t))
    ) u_cordic_el (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p1_valid_reg),
        .in_x      (p1_r_reg),
        .in_y      (p1_kz_reg),
        .in_side   (p1_side_reg),
        .out_valid (b_valid),
        .out_x     (),
        .out_angle (b_angle),
        .out_side  (b_side)
    );

    // elevation clamp to the field of view, time partial products
    logic signed [AW-1:0] fmin;
    logic signed [AW-1:0] fmax;
    logic signed [AW-1:0] span;
    logic signed [AW-1:0] elev;
    logic signed [AW-1:0] num_w;
    logic                 ring_zero;

    always_comb
    begin
        fmin      = AW'(fov_min_reg) <<< 14;
        fmax      = AW'(fov_max_reg) <<< 14;
        span      = fmax - fmin;
        ring_zero = (span <= 0) || (lines_reg == '0);
        elev      = b_side.origin ? '0 : b_angle;
        if (elev > fmax)
        begin
            elev = fmax;
        end
        if (elev < fmin)
        begin
            elev = fmin;
        end
        num_w = elev - fmin;
    end

    logic              p2_valid_reg;
    logic [32:0]       p2_num_reg;
    logic [32:0]       p2_span_reg;
    logic [7:0]        p2_top_reg;
    logic              p2_zero_reg;
    logic [46:0]       p2_pp_hi_reg;
    logic [45:0]       p2_pp_lo_reg;
    lprta_pkg::point_t p2_pt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p2_valid_reg <= b_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        p2_num_reg   <= num_w[32:0];
        p2_span_reg  <= span[32:0];
        p2_top_reg   <= lines_reg - 8'd1;
        p2_zero_reg  <= ring_zero;
        p2_pp_hi_reg <= 47'(b_side.az[32:16]) * 47'(period_reg);
        p2_pp_lo_reg <= 46'(b_side.az[15:0]) * 46'(period_reg);
        p2_pt_reg    <= b_side.pt;
    end

    // dividends: ring with half-up rounding, time with half rotation offset
    logic       p3_valid_reg;
    logic [41:0] p3_ring_num_reg;
    logic [33:0] p3_ring_den_reg;
    rd_side_t   p3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p3_valid_reg <= 1'b0;
        end
        else
        begin
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p3_ring_num_reg       <= 42'(p2_num_reg) * 42'({p2_top_reg, 1'b0})
                                 + 42'(p2_span_reg);
        p3_ring_den_reg       <= {p2_span_reg, 1'b0};
        p3_side_reg.time_num  <= 63'({p2_pp_hi_reg, 16'b0}) + 63'(p2_pp_lo_reg)
                                 + 63'(lprta_pkg::PI_Q30);
        p3_side_reg.ring_zero <= p2_zero_reg;
        p3_side_reg.top       <= p2_top_reg;
        p3_side_reg.pt        <= p2_pt_reg;
    end

    // ring divider
    logic       rd_valid;
    logic [7:0] rd_quo;
    rd_side_t   rd_side;
    td_side_t   td_in_side;

    lprta_div #(
        .NUM_W  (42),
        .DEN_W  (34),
        .QUO_W  (8),
        .SIDE_W ($bits(rd_side_t))
    ) u_div_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p3_valid_reg),
        .in_num    (p3_ring_num_reg),
        .in_den    (p3_ring_den_reg),
        .in_side   (p3_side_reg),
        .out_valid (rd_valid),
        .out_quo   (rd_quo),
        .out_side  (rd_side)
    );

    assign td_in_side.ring_q    = rd_quo;
    assign td_in_side.ring_zero = rd_side.ring_zero;
    assign td_in_side.top       = rd_side.top;
    assign td_in_side.pt        = rd_side.pt;

    // time estimate from the reciprocal of two pi, at most one short
    logic        t1_valid_reg;
    logic [29:0] t1_q_reg;
    logic [35:0] t1_num_reg;
    td_side_t    t1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
        end
        else
        begin
            t1_valid_reg <= rd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_q_reg    <= 30'((64'(rd_side.time_num[62:31])
                            * 64'(lprta_pkg::TWO_PI_RECIP)) >> 33);
        t1_num_reg  <= rd_side.time_num[35:0];
        t1_side_reg <= td_in_side;
    end

    // remainder of the estimate, below a few multiples of two pi
    logic        t2_valid_reg;
    logic [29:0] t2_q_reg;
    logic [35:0] t2_rem_reg;
    td_side_t    t2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t2_valid_reg <= 1'b0;
        end
        else
        begin
            t2_valid_reg <= t1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t2_q_reg    <= t1_q_reg;
        t2_rem_reg  <= t1_num_reg - 36'(63'(t1_q_reg) * 63'(lprta_pkg::TWO_PI_Q30));
        t2_side_reg <= t1_side_reg;
    end

    // result assembly
    logic [7:0]         ring_lim;
    logic [6:0]         ring_sel;
    logic [29:0]        time_fix;
    lprta_pkg::result_t result_next;

    always_comb
    begin
        if (t2_rem_reg >= 36'({lprta_pkg::TWO_PI_Q30, 1'b0}))
        begin
            time_fix = t2_q_reg + 30'd2;
        end
        else if (t2_rem_reg >= 36'(lprta_pkg::TWO_PI_Q30))
        begin
            time_fix = t2_q_reg + 30'd1;
        end
        else
        begin
            time_fix = t2_q_reg;
        end

        ring_lim = (t2_side_reg.ring_q > t2_side_reg.top) ? t2_side_reg.top
                                                          : t2_side_reg.ring_q;
        if (ring_sup_reg)
        begin
            ring_sel = (t2_side_reg.pt.in_ring > 16'd127) ? 7'd127
                                                          : t2_side_reg.pt.in_ring[6:0];
        end
        else if (t2_side_reg.ring_zero)
        begin
            ring_sel = '0;
        end
        else
        begin
            ring_sel = (ring_lim > 8'd127) ? 7'd127 : ring_lim[6:0];
        end

        result_next.out_x          = t2_side_reg.pt.x_pos;
        result_next.out_y          = t2_side_reg.pt.y_pos;
        result_next.out_z          = t2_side_reg.pt.z_pos;
        result_next.intensity      = int_sup_reg ? t2_side_reg.pt.in_intensity : '0;
        result_next.ring_index     = ring_sel;
        result_next.time_offset_ns = time_fix;
        result_next.cloud_end      = t2_side_reg.pt.last_point;
    end

    logic               done_reg;
    lprta_pkg::result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= t2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // checks
    a_intensity_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !int_sup_reg |-> result.intensity == '0)
        else $error("intensity not cleared when not supplied");

    a_ring_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && !ring_sup_reg && lines_reg != '0 |->
        8'(result.ring_index) <= lines_reg - 8'd1)
        else $error("computed ring beyond last line");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.time_offset_ns <= period_reg)
        else $error("time offset beyond scan period");

    a_az_range: assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg |-> p1_side_reg.az < lprta_pkg::TWO_PI_Q30)
        else $error("azimuth outside one rotation");

endmodule

// ----- test/lidar_point_ring_time_annotator_unit_tb.sv -----
`timescale 1ns / 1ps

module lidar_point_ring_time_annotator_unit_tb;

    localparam int STEPS       = 16;
    localparam int LATENCY     = 2 * STEPS + 15;
    localparam int WATCHDOG    = 2000;
    localparam int RANDOM_ITEMS = 1500;

    typedef struct {
        lprta_pkg::point_t  pt;
        logic               has_gold;
        lprta_pkg::result_t gold;
    } stim_row_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    logic     cfg_wr_en;
    logic [lprta_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lprta_pkg::CFG_DATA_W-1:0] cfg_data;
    lprta_pkg::point_t   point;
    logic     done;
    lprta_pkg::result_t  result;

    // local copy of the register file
    logic signed [17:0] fov_min_q;
    logic signed [17:0] fov_max_q;
    logic [7:0]         line_count_q;
    logic [29:0]        period_q;
    logic               ring_pass_q;
    logic               int_pass_q;

    lprta_pkg::result_t annotation_queue[$];
    int      fail_count = 0;
    int      idle_cycles = 0;
    int      sender_idle_pct;

    lidar_point_ring_time_annotator_unit #(.CORDIC_STEPS(STEPS)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .point(point), .done(done), .result(result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // arithmetic shift right rounding toward minus infinity
    function automatic longint shr_floor(input longint v, input int s);
        return v >>> ((s > 62) ? 62 : s);
    endfunction

    function automatic longint atan_step(input int i);
        longint tbl[11];
        tbl = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                16775851, 8388437, 4194283, 2097149, 1048576};
        if (i < 11)
            return tbl[i];
        if (i > 62)
            return 0;
        return longint'((64'd1 << 30) >> i);
    endfunction

    // cordic vectoring, returns angle in rad * 2^30
    function automatic longint rotate_to_axis(inout longint vx, inout longint vy);
        longint ang;
        longint dx;
        longint dy;
        ang = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = shr_floor(vy, i);
            dy = shr_floor(vx, i);
            if (vy >= 0)
            begin
                vx += dx; vy -= dy; ang += atan_step(i);
            end
            else
            begin
                vx -= dx; vy += dy; ang -= atan_step(i);
            end
        end
        return ang;
    endfunction

    function automatic lprta_pkg::result_t annotate_point(input lprta_pkg::point_t p);
        lprta_pkg::result_t r;
        longint x, y, z, vx, vy, a, rad, az, zx, zy, kz, e, ex, ey;
        longint fmin, fmax, span, pi_l, two_pi_l;
        logic [63:0] ring, tim, top, num;
        pi_l = longint'(lprta_pkg::PI_Q30);
        two_pi_l = longint'(lprta_pkg::TWO_PI_Q30);
        x = p.x_pos; y = p.y_pos; z = p.z_pos;
        vx = (x < 0 ? -x : x) * 65536;
        vy = (y < 0 ? -y : y) * 65536;
        a = rotate_to_axis(vx, vy);
        rad = vx;
        // azimuth into one full turn
        if (x == 0 && y == 0)
            az = 0;
        else if (x >= 0 && y >= 0)
            az = a;
        else if (x < 0 && y >= 0)
            az = pi_l - a;
        else if (x < 0)
            az = pi_l + a;
        else
            az = two_pi_l - a;
        if (az < 0)
            az = 0;
        if (az > two_pi_l - 1)
            az = two_pi_l - 1;
        tim = (64'(az) * 64'(period_q) + 64'(pi_l)) / 64'(two_pi_l);
        // elevation with z carrying the same gain
        zx = (z < 0 ? -z : z) * 65536;
        zy = 0;
        void'(rotate_to_axis(zx, zy));
        kz = (z < 0) ? -zx : zx;
        if (rad == 0 && kz == 0)
            e = 0;
        else
        begin
            ex = rad; ey = kz;
            e = rotate_to_axis(ex, ey);
        end
        if (ring_pass_q)
            ring = (p.in_ring > 127) ? 127 : p.in_ring;
        else
        begin
            fmin = longint'(fov_min_q) * 16384;
            fmax = longint'(fov_max_q) * 16384;
            span = fmax - fmin;
            if (span <= 0 || line_count_q == 0)
                ring = 0;
            else
            begin
                top = line_count_q - 1;
                if (e > fmax) e = fmax;
                if (e < fmin) e = fmin;
                num = 64'(e - fmin);
                ring = (num * 2 * top + 64'(span)) / (2 * 64'(span));
                if (ring > top) ring = top;
                if (ring > 127) ring = 127;
            end
        end
        r.out_x = p.x_pos;
        r.out_y = p.y_pos;
        r.out_z = p.z_pos;
        r.intensity = int_pass_q ? p.in_intensity : 32'd0;
        r.ring_index = ring[6:0];
        r.time_offset_ns = tim[29:0];
        r.cloud_end = p.last_point;
        return r;
    endfunction

    // enable is left high; the caller lowers it after the last write
    task automatic write_reg(input logic [lprta_pkg::CFG_IDX_W-1:0] idx, input longint val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[lprta_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        case (idx)
            lprta_pkg::REG_FOV_MIN:       fov_min_q = val[17:0];
            lprta_pkg::REG_FOV_MAX:       fov_max_q = val[17:0];
            lprta_pkg::REG_LINE_COUNT:    line_count_q = val[7:0];
            lprta_pkg::REG_SCAN_PERIOD:   period_q = val[29:0];
            lprta_pkg::REG_RING_SUPPLIED: ring_pass_q = val[0];
            lprta_pkg::REG_INT_SUPPLIED:  int_pass_q = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input longint fmin, input longint fmax, input longint lines,
                              input longint period, input bit rp, input bit ip);
        write_reg(lprta_pkg::REG_FOV_MIN, fmin);
        write_reg(lprta_pkg::REG_FOV_MAX, fmax);
        write_reg(lprta_pkg::REG_LINE_COUNT, lines);
        write_reg(lprta_pkg::REG_SCAN_PERIOD, period);
        write_reg(lprta_pkg::REG_RING_SUPPLIED, rp);
        write_reg(lprta_pkg::REG_INT_SUPPLIED, ip);
        cfg_wr_en <= 1'b0;
    endtask

    // one transfer into the block; the expectation is pushed at acceptance
    task automatic send_point(input lprta_pkg::point_t p, input logic has_gold,
                              input lprta_pkg::result_t gold);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        point <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        annotation_queue.push_back(has_gold ? gold : annotate_point(p));
    endtask

    task automatic drain;
        start <= 1'b0;
        while (annotation_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(131071)) - 65536);
            2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            3: return 32'd0;
            default: return 32'($signed($urandom_range(200 * 65536)) - 100 * 65536);
        endcase
    endfunction

    function automatic lprta_pkg::point_t rand_point();
        lprta_pkg::point_t p;
        p.x_pos = rand_coord();
        p.y_pos = rand_coord();
        p.z_pos = rand_coord();
        p.in_intensity = $urandom;
        p.in_ring = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(140));
        p.last_point = ($urandom_range(15) == 0);
        return p;
    endfunction

    // result check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (annotation_queue.size() == 0)
            begin
                $error("unexpected result transfer");
                fail_count++;
            end
            else
            begin
                lprta_pkg::result_t g;
                g = annotation_queue.pop_front();
                if (result.out_x !== g.out_x)
                begin
                    $error("out_x exp %h got %h", g.out_x, result.out_x); fail_count++;
                end
                if (result.out_y !== g.out_y)
                begin
                    $error("out_y exp %h got %h", g.out_y, result.out_y); fail_count++;
                end
                if (result.out_z !== g.out_z)
                begin
                    $error("out_z exp %h got %h", g.out_z, result.out_z); fail_count++;
                end
                if (result.intensity !== g.intensity)
                begin
                    $error("intensity exp %h got %h", g.intensity, result.intensity);
                    fail_count++;
                end
                if (result.ring_index !== g.ring_index)
                begin
                    $error("ring_index exp %0d got %0d", g.ring_index, result.ring_index);
                    fail_count++;
                end
                if (result.time_offset_ns !== g.time_offset_ns)
                begin
                    $error("time_offset_ns exp %0d got %0d", g.time_offset_ns,
                           result.time_offset_ns);
                    fail_count++;
                end
                if (result.cloud_end !== g.cloud_end)
                begin
                    $error("cloud_end exp %0d got %0d", g.cloud_end, result.cloud_end);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows[$];
        stim_row_t row;
        lprta_pkg::result_t nul;
        int        pcts[4];
        rst_n = 1'b0;
        start = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        point = '0;
        sender_idle_pct = 0;
        nul = '0;
        fov_min_q = -18'sd17157;
        fov_max_q = 18'sd17157;
        line_count_q = 8'd32;
        period_q = 30'd107526882;
        ring_pass_q = 1'b0;
        int_pass_q = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: origin, extremes, quadrants, last point
        row.has_gold = 1'b1;
        row.pt = '0;
        row.gold = nul;
        row.gold.ring_index = 7'd16;
        rows.push_back(row);
        row.pt = '{32'sd0, 32'sd0, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1};
        row.gold = '{32'sd0, 32'sd0, 32'sh7FFF_FFFF, 32'd0, 7'd31, 30'd0, 1'b1};
        rows.push_back(row);
        row.pt = '{32'sd0, 32'sd0, 32'sh8000_0000, 32'h0, 16'h0, 1'b0};
        row.gold = '{32'sd0, 32'sd0, 32'sh8000_0000, 32'd0, 7'd0, 30'd0, 1'b0};
        rows.push_back(row);
        row.has_gold = 1'b0;
        row.pt = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'h5A5A_A5A5, 16'd7, 1'b0};
        rows.push_back(row);
        row.pt = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'h0, 16'd200, 1'b1};
        rows.push_back(row);
        row.pt = '{-32'sd65536, 32'sd65536, 32'sd0, 32'h1, 16'd127, 1'b0};
        rows.push_back(row);
        row.pt = '{-32'sd65536, -32'sd65536, 32'sd6554, 32'h2, 16'd128, 1'b0};
        rows.push_back(row);
        row.pt = '{32'sd65536, -32'sd65536, -32'sd6554, 32'h3, 16'd0, 1'b1};
        rows.push_back(row);
        row.pt = '{32'sd65536, -32'sd1, 32'sd0, 32'h4, 16'd1, 1'b0};
        rows.push_back(row);
        row.pt = '{-32'sd65536, 32'sd0, 32'sd0, 32'h5, 16'd2, 1'b0};
        rows.push_back(row);

        foreach (rows[i])
            send_point(rows[i].pt, rows[i].has_gold, rows[i].gold);
        drain();

        // same rows under pass-through and odd settings
        set_config(102944, -102944, 0, 0, 1'b1, 1'b1);
        foreach (rows[i])
            send_point(rows[i].pt, 1'b0, nul);
        drain();
        set_config(-102944, 102944, 255, 30'h3FFF_FFFF, 1'b0, 1'b0);
        foreach (rows[i])
            send_point(rows[i].pt, 1'b0, nul);
        drain();

        // random phases with different idling and settings
        pcts = '{0, 75, 0, 15};
        for (int ph = 0; ph < 8; ph++)
        begin
            sender_idle_pct = pcts[ph % 4];
            case (ph)
                0: set_config(-17157, 17157, 32, 107526882, 1'b0, 1'b0);
                1: set_config(-102944, 102944, 128, 1000000000, 1'b0, 1'b1);
                2: set_config(0, 1, 1, 1, 1'b1, 1'b0);
                3: set_config(-5000, 60000, 64, 100000000, 1'b0, 1'b1);
                4: set_config(10000, 10000, 16, 1, 1'b0, 1'b0);
                5: set_config(-102944, 0, 200, 536870911, 1'b0, 1'b1);
                default: set_config($signed($urandom_range(205888)) - 102944,
                                    $signed($urandom_range(205888)) - 102944,
                                    $urandom_range(255), $urandom, $urandom_range(1),
                                    $urandom_range(1));
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 8; n++)
                send_point(rand_point(), 1'b0, nul);
            drain();
        end

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
design/lprta_pkg.sv
design/lprta_cordic.sv
design/lprta_div.sv
design/lidar_point_ring_time_annotator_unit.sv
test/lidar_point_ring_time_annotator_unit_tb.sv
